// ----- hw/rtl/pfa_pkg.sv -----
// Shared types and constants for the surface descriptor find-or-allocate block.
package pfa_pkg;

    // One stored surface descriptor; height sits in the lowest bits.
    typedef struct packed {
        logic [7:0]  special;
        logic [7:0]  light;
        logic [15:0] texture;
        logic [31:0] height;
    } entry_t;

    // Special codes below this floor are folded to zero before lookup.
    localparam logic [7:0] SPECIAL_FLOOR = 8'd150;

    // Request codes carried in the slave tuser bit.
    localparam logic FUNC_CLEAR = 1'b0;
    localparam logic FUNC_FIND  = 1'b1;

endpackage

// ----- hw/rtl/plane_find_or_allocate_top.sv -----
// Top level: request sequencer, descriptor table and output register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tdata: height[31:0] texture[47:32]
//          |           |                    |        light[55:48] special[63:56]
//          |           |                    | tuser: func (0 clear, 1 find/allocate)
//  m_*     | out       | m_tvalid/m_tready  | tdata: entry_index[6:0], zero bit 7
//          |           |                    | tuser: newly_allocated[0] table_overflow[1]
//  cfg_*   | in        | cfg_wr_en          | cfg_wr_data: sky texture number
//
// Sequencing: a clear goes from accept straight to the done state. A find reads one
// stored entry per cycle through the registered table read and the compare unit; a hit
// ends the search, and a miss on the last entry (or an empty table) appends the key or
// flags overflow. The next request is taken only once the result has moved into the
// output register: the single table read port and the one compare unit serve one search.
// Reset: control state and the entry count clear at once; table contents are
// left as they are and are never read before they are written.
// Stalls: the result sits in the output register; a new transaction is taken
// while it waits, and the sequencer holds its next result until the register frees.
module plane_find_or_allocate_top
    import pfa_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // height[31:0], texture[47:32], light[55:48], special[63:56]
    input  logic        s_tuser,     // func

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // entry_index[6:0], zero fill [7]
    output logic [1:0]  m_tuser,     // newly_allocated[0], table_overflow[1]

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data  // sky texture number
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t           state_reg;
    entry_t           key_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] issue_reg;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic             res_new_reg;
    logic             res_ovf_reg;
    logic [15:0]      sky_reg;
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;
    logic [1:0]       m_tuser_reg;

    entry_t           in_raw;
    entry_t           in_key;
    entry_t           rd_data;
    logic             accept;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             hit;
    logic             last_cmp;
    logic             full;
    logic             no_match;
    logic             wr_en;
    logic             out_load;
    logic [IDX_W+6:0] res_idx_wide;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Normalize the key: fold low specials, merge sky surfaces that differ only in height and light.
    assign in_raw = entry_t'(s_tdata);
    always_comb
    begin
        in_key = in_raw;
        if (in_raw.special < SPECIAL_FLOOR)
        begin
            in_key.special = 8'd0;
        end
        if (in_raw.texture == sky_reg)
        begin
            in_key.height = 32'd0;
            in_key.light  = 8'd0;
        end
    end

    // Read stream: one address per cycle while entries remain.
    assign rd_en   = (state_reg == S_SCAN) && (issue_reg < count_reg);
    assign rd_addr = issue_reg[IDX_W-1:0];

    pfa_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pfa_match u_match (
        .cmp_valid (cmp_valid_reg),
        .stored    (rd_data),
        .key       (key_reg),
        .hit       (hit)
    );

    // Search ends with no hit when the table is empty or the last entry missed.
    assign last_cmp = (CNT_W'(cmp_idx_reg) + CNT_W'(1)) == count_reg;
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign no_match = (state_reg == S_SCAN) &&
                      ((count_reg == '0) || (cmp_valid_reg && !hit && last_cmp));
    assign wr_en    = no_match && !full;

    assign out_load     = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    assign res_idx_wide = {7'd0, res_idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_reg       <= '0;
            count_reg     <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            res_idx_reg   <= '0;
            res_new_reg   <= 1'b0;
            res_ovf_reg   <= 1'b0;
            sky_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sky_reg <= cfg_wr_data;
            end

            // Read pipeline tag follows the table's registered data.
            cmp_valid_reg <= rd_en;
            if (rd_en)
            begin
                cmp_idx_reg <= rd_addr;
                issue_reg   <= issue_reg + CNT_W'(1);
            end

            // Output register: refill wins over drain in the same cycle.
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg   <= in_key;
                        issue_reg <= '0;
                        if (s_tuser == FUNC_CLEAR)
                        begin
                            count_reg   <= '0;
                            res_idx_reg <= '0;
                            res_new_reg <= 1'b0;
                            res_ovf_reg <= 1'b0;
                            state_reg   <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        res_idx_reg <= cmp_idx_reg;
                        res_new_reg <= 1'b0;
                        res_ovf_reg <= 1'b0;
                        state_reg   <= S_DONE;
                    end
                    else if (no_match)
                    begin
                        if (full)
                        begin
                            res_idx_reg <= '0;
                            res_new_reg <= 1'b0;
                            res_ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            res_idx_reg <= count_reg[IDX_W-1:0];
                            res_new_reg <= 1'b1;
                            res_ovf_reg <= 1'b0;
                            count_reg   <= count_reg + CNT_W'(1);
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        m_tdata_reg  <= {1'b0, res_idx_wide[6:0]};
                        m_tuser_reg  <= {res_ovf_reg, res_new_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- hw/rtl/pfa_table.sv -----
// Descriptor storage: one write port, one read port with registered read data.
module pfa_table
    import pfa_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int IDX_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/pfa_match.sv -----
// Shared compare unit: checks one fetched descriptor against the search key.
module pfa_match
    import pfa_pkg::*;
(
    input  logic   cmp_valid,
    input  entry_t stored,
    input  entry_t key,
    output logic   hit
);

    logic height_eq;
    logic texture_eq;
    logic light_eq;
    logic special_eq;

    assign height_eq  = (stored.height  == key.height);
    assign texture_eq = (stored.texture == key.texture);
    assign light_eq   = (stored.light   == key.light);
    assign special_eq = (stored.special == key.special);

    assign hit = cmp_valid && height_eq && texture_eq && light_eq && special_eq;

endmodule

// ----- bench/plane_find_or_allocate_top_tb.sv -----
// Self-checking bench for plane_find_or_allocate_top against a table predictor.
module plane_find_or_allocate_top_tb
    import pfa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 128;
    // Slowest legal run: ~930 transactions, each a full-table search with the longest
    // sender gap and the longest receiver stall.
    // Hang detection sits well above that.
    localparam int CYCLE_LIMIT = 1_000_000;

    // func travels in tuser, the descriptor in tdata (height in the lowest bits)
    typedef struct packed {
        logic   func;
        entry_t surf;
    } request_t;

    typedef struct packed {
        logic [6:0] index;
        logic       fresh;
        logic       overflow;
    } outcome_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;     // height[31:0], texture[47:32], light[55:48], special[63:56]
    logic        s_tuser = 1'b0;   // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // entry_index[6:0], zero fill [7]
    logic [1:0]  m_tuser;          // newly_allocated[0], table_overflow[1]
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0; // sky texture number

    // Predictor state: its own copy of the descriptor table and the sky register
    entry_t      surface_table [DEPTH];
    int          surface_count = 0;
    logic [15:0] sky_texture = '0;

    request_t pending_requests [$];    // filled by the sequence, drained by the driver
    outcome_t expected_outcomes [$];   // one per accepted transaction, oldest first

    int       error_count = 0;
    int       cycle_count = 0;
    int       items_queued = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    logic     quiet;
    request_t next_request;
    request_t seen_request;
    outcome_t wanted;

    plane_find_or_allocate_top #(
        .TABLE_DEPTH (DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Periodic stretches where neither side idles, so back-to-back traffic is seen too
    assign quiet = (cycle_count % 3000) < 600;

    // Clear empties the table; find folds special and sky, searches from index 0,
    // appends on a miss, or flags overflow when the table is already full.
    function automatic outcome_t find_or_allocate(request_t req);
        entry_t   key;
        outcome_t res;
        int       i;
        key = req.surf;
        res = '0;
        if (req.func == FUNC_CLEAR)
        begin
            surface_count = 0;
            return res;
        end
        if (key.special < SPECIAL_FLOOR)
            key.special = '0;
        if (key.texture == sky_texture)
        begin
            key.height = '0;
            key.light  = '0;
        end
        for (i = 0; i < surface_count; i++)
        begin
            if (surface_table[i] == key)
            begin
                res.index = i[6:0];
                return res;
            end
        end
        if (surface_count >= DEPTH)
        begin
            res.overflow = 1'b1;
            return res;
        end
        surface_table[surface_count] = key;
        res.index = surface_count[6:0];
        res.fresh = 1'b1;
        surface_count++;
        return res;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        if (r < 85)
            return int'($urandom_range(1, 3));
        if (r < 97)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic entry_t random_surface(logic [15:0] sky);
        entry_t e;
        e.height  = $urandom;
        e.texture = 16'($urandom);
        e.light   = 8'($urandom);
        e.special = 8'($urandom);
        case ($urandom_range(0, 11))
            0: e.height = 32'h0000_0000;
            1: e.height = 32'h7FFF_FFFF;
            2: e.height = 32'h8000_0000;
            3: e.height = 32'hFFFF_FFFF;
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0, 1: e.texture = sky;
            2:    e.texture = sky ^ 16'h0001;
            3:    e.texture = 16'($urandom_range(0, 15));
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0: e.special = 8'd149;
            1: e.special = SPECIAL_FLOOR;
            2: e.special = 8'($urandom_range(0, 149));
            default: ;
        endcase
        return e;
    endfunction

    task automatic queue_request(logic func, entry_t surf);
        request_t r;
        r.func = func;
        r.surf = surf;
        pending_requests.push_back(r);
        items_queued++;
    endtask

    task automatic queue_find(logic [31:0] h, logic [15:0] t, logic [7:0] l, logic [7:0] s);
        entry_t e;
        e.height  = h;
        e.texture = t;
        e.light   = l;
        e.special = s;
        queue_request(FUNC_FIND, e);
    endtask

    // One frame: clear, optionally sweep the whole pool in order (fills the table),
    // then random picks from the pool with stray requests and mid-frame clears.
    task automatic queue_frame(int finds, int pool_size, bit sweep, logic [15:0] sky);
        entry_t pool [$];
        entry_t s;
        int     k;
        int     r;
        queue_request(FUNC_CLEAR, {$urandom, $urandom});
        for (k = 0; k < pool_size; k++)
            pool.push_back(random_surface(sky));
        if (sweep)
        begin
            for (k = 0; k < pool_size; k++)
                queue_request(FUNC_FIND, pool[k]);
        end
        for (k = 0; k < finds; k++)
        begin
            r = int'($urandom_range(0, 99));
            if (r < 78)
            begin
                // same descriptor after folding, different raw bits where folding allows
                s = pool[$urandom_range(0, pool_size - 1)];
                if (s.special < SPECIAL_FLOOR)
                    s.special = 8'($urandom_range(0, 149));
                if (s.texture == sky)
                begin
                    s.height = $urandom;
                    s.light  = 8'($urandom);
                end
                queue_request(FUNC_FIND, s);
            end
            else if (r < 96)
                queue_request(FUNC_FIND, random_surface(sky));
            else
                queue_request(FUNC_CLEAR, {$urandom, $urandom});
        end
    endtask

    task automatic queue_small_frames(int upto, logic [15:0] sky);
        while (items_queued < upto)
            queue_frame($urandom_range(1, 40),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 12),
                        $urandom_range(0, 3) == 0, sky);
    endtask

    task automatic write_sky(logic [15:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Sender holds off until every expected result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_outcomes.size() != 0);
    endtask

    // Sequence: reset, then phases at different sky settings, config only while idle
    initial
    begin
        logic [15:0] sky;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, special folding around the floor, sky merging,
        // hits and misses on single-field differences, clears (also back to back)
        write_sky(16'h0000);
        @(negedge clk);
        queue_request(FUNC_CLEAR, '1);
        queue_find(32'hFFFF_FFFF, 16'h0000, 8'hFF, 8'hFF);   // sky: height/light forced
        queue_find(32'h0000_0000, 16'h0000, 8'h00, 8'h00);
        queue_find(32'h8000_0000, 16'h0000, 8'h80, 8'd149);  // sky, folds onto previous
        queue_find(32'h7FFF_FFFF, 16'hFFFF, 8'hFF, 8'd149);
        queue_find(32'h7FFF_FFFF, 16'hFFFF, 8'hFF, 8'h00);   // hit after folding
        queue_find(32'h7FFF_FFFF, 16'hFFFF, 8'hFF, 8'd150);  // floor value is kept
        queue_find(32'h7FFF_FFFF, 16'hFFFF, 8'hFF, 8'd151);
        queue_find(32'h8000_0000, 16'h0001, 8'h00, 8'hFF);
        queue_find(32'h8000_0000, 16'h0001, 8'h01, 8'hFF);   // light differs
        queue_find(32'h8000_0001, 16'h0001, 8'h00, 8'hFF);   // height differs
        queue_find(32'h8000_0000, 16'h0001, 8'h00, 8'hFF);
        queue_find(32'h7FFF_FFFF, 16'hFFFF, 8'hFF, 8'd149);
        queue_request(FUNC_CLEAR, '0);
        queue_find(32'h8000_0000, 16'h0001, 8'h00, 8'hFF);   // reallocated at 0
        queue_request(FUNC_CLEAR, '0);
        queue_request(FUNC_CLEAR, '1);
        queue_find(32'h0001_0000, 16'h8000, 8'h55, 8'hAA);
        queue_find(32'h0001_0000, 16'h8000, 8'h55, 8'hAA);
        wait_drained();

        // Top sky value; table left over from the previous phase on purpose
        sky = 16'hFFFF;
        write_sky(sky);
        @(negedge clk);
        queue_find(32'h1234_5678, 16'hFFFF, 8'h09, 8'd200);
        queue_find(32'h0000_0000, 16'hFFFF, 8'h00, 8'd201);
        queue_find(32'h0000_0005, 16'hFFFF, 8'h03, 8'd200);
        queue_small_frames(150, sky);
        queue_frame(60, 170, 1'b1, sky);                      // fills and overflows
        wait_drained();

        sky = 16'($urandom);
        write_sky(sky);
        @(negedge clk);
        queue_small_frames(500, sky);
        queue_frame(60, 170, 1'b1, sky);
        wait_drained();

        sky = 16'($urandom);
        write_sky(sky);
        @(negedge clk);
        queue_small_frames(830, sky);
        wait_drained();

        // Let any stray result surface before the final check
        repeat (DEPTH + 8) @(posedge clk);
        if (error_count == 0 && expected_outcomes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Driver: one transaction per handshake, random gaps after each accept
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                next_request = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_request.surf;
                s_tuser  <= next_request.func;
                send_gap = quiet ? 0 : pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver backpressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = pick_gap();
        end
        else
            m_tready <= 1'b1;
    end

    // Monitor: predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sky_texture = cfg_wr_data;
            if (s_tvalid && s_tready)
            begin
                seen_request = {s_tuser, s_tdata};
                expected_outcomes.push_back(find_or_allocate(seen_request));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result with no request outstanding: entry_index %0d", m_tdata[6:0]);
                    error_count++;
                end
                else
                begin
                    wanted = expected_outcomes.pop_front();
                    if (m_tdata[6:0] !== wanted.index)
                    begin
                        $error("entry_index: expected %0d, actual %0d", wanted.index, m_tdata[6:0]);
                        error_count++;
                    end
                    if (m_tuser[0] !== wanted.fresh)
                    begin
                        $error("newly_allocated: expected %0b, actual %0b", wanted.fresh, m_tuser[0]);
                        error_count++;
                    end
                    if (m_tuser[1] !== wanted.overflow)
                    begin
                        $error("table_overflow: expected %0b, actual %0b",
                               wanted.overflow, m_tuser[1]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
